### rtl/iplpr_pkg.sv
// Shared types and codes for the IPv4 longest-prefix route table.
// Used by iplpr_entry_ram and ipv4_longest_prefix_route_table_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package iplpr_pkg;

    localparam int ADDR_W   = 32;
    localparam int IFIDX_W  = 2;
    localparam int NUM_CFG_IFACES = 4;
    localparam int CFG_IDX_W = 3;
    localparam int IFCNT_W  = 3;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IFACE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IFACE0_ADDR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IFACE1_ADDR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IFACE2_ADDR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IFACE3_ADDR = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  subnet;
        logic [ADDR_W-1:0]  gateway;
        logic [ADDR_W-1:0]  iface_addr;
        logic [IFIDX_W-1:0] iface_index;
        logic               iface_known;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_IFACE,
        S_WRITE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage
`default_nettype wire

### rtl/iplpr_entry_ram.sv
// Route entry memory: one write port, one read port with registered read data.
// Depends on iplpr_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module iplpr_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  wire [AW-1:0]         i_waddr,
    input  wire iplpr_pkg::t_entry i_wdata,
    input  wire [AW-1:0]         i_raddr,
    output iplpr_pkg::t_entry    o_rdata
);

    iplpr_pkg::t_entry r_mem [DEPTH];
    iplpr_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/ipv4_longest_prefix_route_table_unit.sv
// IPv4 route table with longest-prefix lookup, sequenced over one shared compare unit.
// Depends on iplpr_pkg and iplpr_entry_ram.
//
//   channel   ports                                         handshake
//   command   i_command i_address i_mask i_gateway_addr     i_start, o_busy
//             i_out_iface_addr
//   result    o_status o_hit_dest o_hit_mask o_hit_gateway  o_done (one-cycle strobe)
//             o_hit_iface_addr o_hit_iface_index o_hit_iface_known
//   config    i_cfg_index i_cfg_data                        i_cfg_we
//
// Lookup: one entry read per cycle through the single memory read port, then the
// drain and finish states; an empty table answers straight from idle. Insert: one
// interface compare per cycle over min(iface_count, NUM_IFACES) interfaces, then
// the write. Clear is answered straight from idle.
// Reset is synchronous, active low; it empties the table and zeros the config.
// o_busy is low in the cycle o_done is high, so a new word may follow at once.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_longest_prefix_route_table_unit #(
    parameter int MAX_ROUTES = 16,
    parameter int NUM_IFACES = 4
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_start,
    output logic                                 o_busy,
    input  wire  [1:0]                           i_command,
    input  wire  [iplpr_pkg::ADDR_W-1:0]         i_address,
    input  wire  [iplpr_pkg::ADDR_W-1:0]         i_mask,
    input  wire  [iplpr_pkg::ADDR_W-1:0]         i_gateway_addr,
    input  wire  [iplpr_pkg::ADDR_W-1:0]         i_out_iface_addr,
    input  wire                                  i_cfg_we,
    input  wire  [iplpr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [iplpr_pkg::ADDR_W-1:0]         i_cfg_data,
    output logic                                 o_done,
    output logic [1:0]                           o_status,
    output logic [iplpr_pkg::ADDR_W-1:0]         o_hit_dest,
    output logic [iplpr_pkg::ADDR_W-1:0]         o_hit_mask,
    output logic [iplpr_pkg::ADDR_W-1:0]         o_hit_gateway,
    output logic [iplpr_pkg::ADDR_W-1:0]         o_hit_iface_addr,
    output logic [iplpr_pkg::IFIDX_W-1:0]        o_hit_iface_index,
    output logic                                 o_hit_iface_known
);

    localparam int AW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CW = $clog2(MAX_ROUTES + 1);
    localparam int IW = iplpr_pkg::IFIDX_W;
    localparam int NW = iplpr_pkg::IFCNT_W;

    iplpr_pkg::t_state r_state, n_state;

    logic [iplpr_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [iplpr_pkg::ADDR_W-1:0] r_mask, n_mask;
    logic [iplpr_pkg::ADDR_W-1:0] r_gw, n_gw;
    logic [iplpr_pkg::ADDR_W-1:0] r_ifa, n_ifa;
    logic [CW-1:0]                r_count, n_count;
    logic [AW-1:0]                r_rd_idx, n_rd_idx;
    logic                         r_rd_vld;
    logic [IW-1:0]                r_if_idx, n_if_idx;
    logic [IW-1:0]                r_if_sel, n_if_sel;
    logic                         r_known, n_known;
    logic                         r_found, n_found;
    iplpr_pkg::t_entry            r_best, n_best;

    logic [NW-1:0]                r_iface_count;
    logic [iplpr_pkg::ADDR_W-1:0] r_iface_addr [iplpr_pkg::NUM_CFG_IFACES];

    logic                         r_done, n_done;
    logic [1:0]                   r_status, n_status;
    iplpr_pkg::t_entry            r_hit, n_hit;

    iplpr_pkg::t_entry            rd_entry;
    iplpr_pkg::t_entry            wr_entry;
    logic                         wr_en;

    logic [NW-1:0]                if_lim;
    logic [iplpr_pkg::ADDR_W-1:0] cmp_a, cmp_m, cmp_b;
    logic                         cmp_eq;
    logic                         mask_gt;
    logic                         scan_last;
    logic                         if_last;

    // Entry memory
    assign wr_en = (r_state == iplpr_pkg::S_WRITE);

    always_comb begin
        wr_entry.dest        = r_addr;
        wr_entry.mask        = r_mask;
        wr_entry.subnet      = r_addr & r_mask;
        wr_entry.gateway     = r_gw;
        wr_entry.iface_addr  = r_ifa;
        wr_entry.iface_index = r_known ? r_if_sel : '0;
        wr_entry.iface_known = r_known;
    end

    iplpr_entry_ram #(
        .DEPTH (MAX_ROUTES),
        .AW    (AW)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_entry)
    );

    // Shared masked-equality unit: route match during lookup, interface match on insert
    always_comb begin
        if (r_state == iplpr_pkg::S_IFACE) begin
            cmp_a = r_ifa;
            cmp_m = '1;
            cmp_b = r_iface_addr[r_if_idx];
        end else begin
            cmp_a = r_addr;
            cmp_m = rd_entry.mask;
            cmp_b = rd_entry.subnet;
        end
        cmp_eq = ((cmp_a & cmp_m) == cmp_b);
    end

    assign mask_gt   = (rd_entry.mask > r_best.mask);
    assign if_lim    = (r_iface_count > NW'(NUM_IFACES)) ? NW'(NUM_IFACES) : r_iface_count;
    assign scan_last = ((CW'(r_rd_idx) + CW'(1)) == r_count);
    assign if_last   = ((NW'(r_if_idx) + NW'(1)) == if_lim);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iface_count <= '0;
            for (int k = 0; k < iplpr_pkg::NUM_CFG_IFACES; k++) begin
                r_iface_addr[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                iplpr_pkg::CFG_IFACE_COUNT: r_iface_count   <= i_cfg_data[NW-1:0];
                iplpr_pkg::CFG_IFACE0_ADDR: r_iface_addr[0] <= i_cfg_data;
                iplpr_pkg::CFG_IFACE1_ADDR: r_iface_addr[1] <= i_cfg_data;
                iplpr_pkg::CFG_IFACE2_ADDR: r_iface_addr[2] <= i_cfg_data;
                iplpr_pkg::CFG_IFACE3_ADDR: r_iface_addr[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_mask   = r_mask;
        n_gw     = r_gw;
        n_ifa    = r_ifa;
        n_count  = r_count;
        n_rd_idx = r_rd_idx;
        n_if_idx = r_if_idx;
        n_if_sel = r_if_sel;
        n_known  = r_known;
        n_found  = r_found;
        n_best   = r_best;
        n_done   = 1'b0;
        n_status = r_status;
        n_hit    = r_hit;

        // compare the word read last cycle
        if (r_rd_vld && cmp_eq && (!r_found || mask_gt)) begin
            n_found = 1'b1;
            n_best  = rd_entry;
        end

        unique case (r_state)
            iplpr_pkg::S_IDLE: begin
                if (i_start) begin
                    n_addr   = i_address;
                    n_mask   = i_mask;
                    n_gw     = i_gateway_addr;
                    n_ifa    = i_out_iface_addr;
                    n_rd_idx = '0;
                    n_if_idx = '0;
                    n_if_sel = '0;
                    n_known  = 1'b0;
                    n_found  = 1'b0;
                    unique case (i_command)
                        iplpr_pkg::CMD_LOOKUP: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_status = iplpr_pkg::STATUS_MISS;
                                n_hit    = '0;
                            end else begin
                                n_state = iplpr_pkg::S_SCAN;
                            end
                        end
                        iplpr_pkg::CMD_INSERT: begin
                            priority if (r_count >= CW'(MAX_ROUTES)) begin
                                n_done   = 1'b1;
                                n_status = iplpr_pkg::STATUS_FULL;
                                n_hit    = '0;
                            end else if (if_lim == '0) begin
                                n_state = iplpr_pkg::S_WRITE;
                            end else begin
                                n_state = iplpr_pkg::S_IFACE;
                            end
                        end
                        iplpr_pkg::CMD_CLEAR: begin
                            n_count  = '0;
                            n_done   = 1'b1;
                            n_status = iplpr_pkg::STATUS_OK;
                            n_hit    = '0;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = iplpr_pkg::STATUS_OK;
                            n_hit    = '0;
                        end
                    endcase
                end
            end
            iplpr_pkg::S_IFACE: begin
                // last match wins
                if (cmp_eq) begin
                    n_known  = 1'b1;
                    n_if_sel = r_if_idx;
                end
                if (if_last) begin
                    n_state = iplpr_pkg::S_WRITE;
                end else begin
                    n_if_idx = r_if_idx + IW'(1);
                end
            end
            iplpr_pkg::S_WRITE: begin
                n_count  = r_count + CW'(1);
                n_done   = 1'b1;
                n_status = iplpr_pkg::STATUS_OK;
                n_hit    = '0;
                n_state  = iplpr_pkg::S_IDLE;
            end
            iplpr_pkg::S_SCAN: begin
                if (scan_last) begin
                    n_state = iplpr_pkg::S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + AW'(1);
                end
            end
            iplpr_pkg::S_DRAIN: begin
                n_state = iplpr_pkg::S_FINISH;
            end
            iplpr_pkg::S_FINISH: begin
                n_done  = 1'b1;
                n_state = iplpr_pkg::S_IDLE;
                if (r_found) begin
                    n_status = iplpr_pkg::STATUS_OK;
                    n_hit    = r_best;
                    n_hit.subnet = '0;
                end else begin
                    n_status = iplpr_pkg::STATUS_MISS;
                    n_hit    = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= iplpr_pkg::S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= (r_state == iplpr_pkg::S_SCAN);
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_mask   <= n_mask;
        r_gw     <= n_gw;
        r_ifa    <= n_ifa;
        r_rd_idx <= n_rd_idx;
        r_if_idx <= n_if_idx;
        r_if_sel <= n_if_sel;
        r_known  <= n_known;
        r_found  <= n_found;
        r_best   <= n_best;
        r_status <= n_status;
        r_hit    <= n_hit;
    end

    assign o_busy            = (r_state != iplpr_pkg::S_IDLE);
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_hit_dest        = r_hit.dest;
    assign o_hit_mask        = r_hit.mask;
    assign o_hit_gateway     = r_hit.gateway;
    assign o_hit_iface_addr  = r_hit.iface_addr;
    assign o_hit_iface_index = r_hit.iface_index;
    assign o_hit_iface_known = r_hit.iface_known;

endmodule
`default_nettype wire
